// ===== hw/rtl/nlpt_pkg.sv =====
// Package for the nearest live point table: shared types, codes and constants.
// No dependencies; every other file of the block refers to it by scoped names.
`default_nettype none

package nlpt_pkg;

  localparam int TABLE_DEPTH_DEF = 1024;
  localparam int COORD_W         = 16;
  localparam int KIND_W          = 2;
  localparam int IDX_W           = 10;
  localparam int NUT_W           = 16;
  localparam int ALIVE_OUT_W     = 11;
  localparam int ALIVE_SAT       = 2047;
  localparam int CFG_IDX_W       = 2;
  localparam int CFG_DATA_W      = 16;
  localparam int NUT_RESET       = 256;
  localparam int MAG_W           = 16;
  localparam int SQ_W            = 32;
  localparam int DIST_W          = 34;

  typedef enum logic [1:0] {
    OP_LOAD   = 2'd0,
    OP_SEARCH = 2'd1,
    OP_EAT    = 2'd2,
    OP_COUNT  = 2'd3
  } op_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_NUT_KIND0 = 2'd0,
    REG_NUT_KIND1 = 2'd1,
    REG_NUT_KIND2 = 2'd2
  } cfg_reg_t;

  typedef enum logic [1:0] {
    KIND_0 = 2'd0,
    KIND_1 = 2'd1,
    KIND_2 = 2'd2
  } kind_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_SCAN,
    ST_EAT_RD,
    ST_EAT_WR,
    ST_COUNT
  } state_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic signed [COORD_W-1:0] z;
    logic [KIND_W-1:0]         kind;
  } point_t;

  typedef struct packed {
    op_t                       opcode;
    logic signed [COORD_W-1:0] pos_x;
    logic signed [COORD_W-1:0] pos_y;
    logic signed [COORD_W-1:0] pos_z;
    logic [KIND_W-1:0]         kind;
    logic [COORD_W-1:0]        radius;
    logic [IDX_W-1:0]          index;
  } item_t;

  typedef struct packed {
    logic                      found;
    logic [IDX_W-1:0]          found_index;
    logic signed [COORD_W-1:0] found_x;
    logic signed [COORD_W-1:0] found_y;
    logic signed [COORD_W-1:0] found_z;
    logic [KIND_W-1:0]         found_kind;
    logic [NUT_W-1:0]          nutrition;
    logic [ALIVE_OUT_W-1:0]    alive_count;
    logic                      status;
  } res_t;

  typedef struct packed {
    logic rd_en;
    logic pt_we;
    logic live_we;
    logic live_wd;
  } tbl_ctl_t;

  typedef struct packed {
    logic   busy;
    logic   hit;
    point_t best;
  } dist_stat_t;

endpackage

`default_nettype wire

// ===== hw/rtl/nlpt_if.sv =====
// Valid/ready channel interfaces for the item input and the result output.
// Field widths come from nlpt_pkg.
`default_nettype none

interface nlpt_in_if;
  logic                                valid;
  logic                                ready;
  logic [1:0]                          opcode;
  logic signed [nlpt_pkg::COORD_W-1:0] pos_x;
  logic signed [nlpt_pkg::COORD_W-1:0] pos_y;
  logic signed [nlpt_pkg::COORD_W-1:0] pos_z;
  logic [nlpt_pkg::KIND_W-1:0]         kind;
  logic [nlpt_pkg::COORD_W-1:0]        radius;
  logic [nlpt_pkg::IDX_W-1:0]          index;

  modport source (output valid, opcode, pos_x, pos_y, pos_z, kind, radius, index,
                  input ready);
  modport sink (input valid, opcode, pos_x, pos_y, pos_z, kind, radius, index,
                output ready);
endinterface

interface nlpt_out_if;
  logic                                valid;
  logic                                ready;
  logic                                found;
  logic [nlpt_pkg::IDX_W-1:0]          found_index;
  logic signed [nlpt_pkg::COORD_W-1:0] found_x;
  logic signed [nlpt_pkg::COORD_W-1:0] found_y;
  logic signed [nlpt_pkg::COORD_W-1:0] found_z;
  logic [nlpt_pkg::KIND_W-1:0]         found_kind;
  logic [nlpt_pkg::NUT_W-1:0]          nutrition;
  logic [nlpt_pkg::ALIVE_OUT_W-1:0]    alive_count;
  logic                                status;

  modport source (output valid, found, found_index, found_x, found_y, found_z,
                  found_kind, nutrition, alive_count, status,
                  input ready);
  modport sink (input valid, found, found_index, found_x, found_y, found_z,
                found_kind, nutrition, alive_count, status,
                output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/nlpt_table.sv =====
// Point storage: a point memory (position and kind) and a live-flag memory,
// each with one write port and one registered read port. Uses nlpt_pkg.
`default_nettype none

module nlpt_table #(
  parameter int TABLE_DEPTH = nlpt_pkg::TABLE_DEPTH_DEF
) (
  input  wire                             clk,
  input  nlpt_pkg::tbl_ctl_t              ctl,
  input  wire [$clog2(TABLE_DEPTH)-1:0]   wr_addr,
  input  wire [$clog2(TABLE_DEPTH)-1:0]   rd_addr,
  input  nlpt_pkg::point_t                wr_point,
  output nlpt_pkg::point_t                rd_point,
  output logic                            rd_live
);

  nlpt_pkg::point_t pt_mem   [TABLE_DEPTH];
  logic             live_mem [TABLE_DEPTH];

  always_ff @(posedge clk) begin
    if (ctl.pt_we) begin
      pt_mem[wr_addr] <= wr_point;
    end
    if (ctl.rd_en) begin
      rd_point <= pt_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.live_we) begin
      live_mem[wr_addr] <= ctl.live_wd;
    end
    if (ctl.rd_en) begin
      rd_live <= live_mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/nlpt_dist.sv =====
// Squared-distance pipeline and best-match tracker for the search scan.
// Takes one table entry per cycle from nlpt_table's read port. Uses nlpt_pkg.
`default_nettype none

module nlpt_dist #(
  parameter int TABLE_DEPTH = nlpt_pkg::TABLE_DEPTH_DEF
) (
  input  wire                                  clk,
  input  wire                                  rst_n,
  input  wire                                  start,
  input  wire [nlpt_pkg::COORD_W-1:0]          radius,
  input  nlpt_pkg::point_t                     query,
  input  wire                                  issue,
  input  wire [$clog2(TABLE_DEPTH)-1:0]        issue_addr,
  input  nlpt_pkg::point_t                     rd_point,
  input  wire                                  rd_live,
  output nlpt_pkg::dist_stat_t                 stat,
  output logic [$clog2(TABLE_DEPTH)-1:0]       best_idx
);

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int DW = nlpt_pkg::COORD_W + 1;

  logic                          v1_r, v2_r, v3_r, v4_r;
  logic [AW-1:0]                 idx1_r, idx2_r, idx3_r, idx4_r;
  logic                          live2_r, live3_r, live4_r;
  nlpt_pkg::point_t              pt2_r, pt3_r, pt4_r;
  logic [nlpt_pkg::MAG_W-1:0]    mx2_r, my2_r, mz2_r;
  logic [nlpt_pkg::SQ_W-1:0]     sx3_r, sy3_r, sz3_r;
  logic [nlpt_pkg::DIST_W-1:0]   sum4_r;
  logic [nlpt_pkg::DIST_W-1:0]   best_r;
  logic                          hit_r;
  nlpt_pkg::point_t              best_pt_r;
  logic [AW-1:0]                 best_idx_r;
  logic signed [DW-1:0]          dx, dy, dz;
  logic [nlpt_pkg::MAG_W-1:0]    mx, my, mz;
  logic [nlpt_pkg::SQ_W-1:0]     rad_sq;

  function automatic logic [nlpt_pkg::MAG_W-1:0] mag(input logic signed [DW-1:0] d);
    logic signed [DW-1:0] n;
    n = -d;
    return d[DW-1] ? n[nlpt_pkg::MAG_W-1:0] : d[nlpt_pkg::MAG_W-1:0];
  endfunction

  assign rad_sq = nlpt_pkg::SQ_W'(radius) * nlpt_pkg::SQ_W'(radius);

  always_comb begin
    dx = DW'(query.x) - DW'(rd_point.x);
    dy = DW'(query.y) - DW'(rd_point.y);
    dz = DW'(query.z) - DW'(rd_point.z);
    mx = mag(dx);
    my = mag(dy);
    mz = mag(dz);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      v1_r <= issue;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    idx1_r  <= issue_addr;
    idx2_r  <= idx1_r;
    live2_r <= rd_live;
    pt2_r   <= rd_point;
    mx2_r   <= mx;
    my2_r   <= my;
    mz2_r   <= mz;
    idx3_r  <= idx2_r;
    live3_r <= live2_r;
    pt3_r   <= pt2_r;
    sx3_r   <= nlpt_pkg::SQ_W'(mx2_r) * nlpt_pkg::SQ_W'(mx2_r);
    sy3_r   <= nlpt_pkg::SQ_W'(my2_r) * nlpt_pkg::SQ_W'(my2_r);
    sz3_r   <= nlpt_pkg::SQ_W'(mz2_r) * nlpt_pkg::SQ_W'(mz2_r);
    idx4_r  <= idx3_r;
    live4_r <= live3_r;
    pt4_r   <= pt3_r;
    sum4_r  <= nlpt_pkg::DIST_W'(sx3_r) + nlpt_pkg::DIST_W'(sy3_r)
             + nlpt_pkg::DIST_W'(sz3_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hit_r <= 1'b0;
    end else if (start) begin
      hit_r <= 1'b0;
    end else if (v4_r && live4_r && (sum4_r < best_r)) begin
      hit_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      best_r <= nlpt_pkg::DIST_W'(rad_sq);
    end else if (v4_r && live4_r && (sum4_r < best_r)) begin
      best_r     <= sum4_r;
      best_pt_r  <= pt4_r;
      best_idx_r <= idx4_r;
    end
  end

  assign stat.busy = v1_r | v2_r | v3_r | v4_r;
  assign stat.hit  = hit_r;
  assign stat.best = best_pt_r;
  assign best_idx  = best_idx_r;

endmodule

`default_nettype wire

// ===== hw/rtl/nearest_live_point_table_unit.sv =====
// Top level of the nearest live point table: control sequencer, registers,
// output register. Uses nlpt_pkg, nlpt_if, nlpt_table and nlpt_dist.
//
// Items arrive on in_ch and each gives exactly one result transaction on out_ch.
// The block takes one item at a time: in_ch.ready is high only while idle, but
// a new item is taken while the previous result still waits in the output
// register. Configuration writes on cfg_we/cfg_index/cfg_data take effect at
// once and are meant to happen only while the block is idle.
// Load and count items pass through their own state into the output register, and
// eat items through ST_EAT_RD and ST_EAT_WR, before out_ch.valid rises.
// A search scans the slots below the load count, one slot per cycle through the
// single read port of the point memory, followed by a four-stage distance
// pipeline; a search reads no slot when the table is empty.
// Live flags are valid only below the load count, so reset needs no clearing
// pass: after reset the table is empty, the load count and live count are zero
// and the nutrition registers hold 256. If out_ch.ready is low, the finished
// result is held in the output register, and the next item stalls at its last
// step until that register is free.
`default_nettype none

module nearest_live_point_table_unit #(
  parameter int TABLE_DEPTH = nlpt_pkg::TABLE_DEPTH_DEF
) (
  input  wire                                clk,
  input  wire                                rst_n,
  nlpt_in_if.sink                            in_ch,
  nlpt_out_if.source                         out_ch,
  input  wire                                cfg_we,
  input  wire [nlpt_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire [nlpt_pkg::CFG_DATA_W-1:0]     cfg_data
);

  localparam int AW   = $clog2(TABLE_DEPTH);
  localparam int CW   = $clog2(TABLE_DEPTH + 1);
  localparam int CMPW = (CW > nlpt_pkg::IDX_W) ? CW : nlpt_pkg::IDX_W;
  localparam int SATW = (CW > nlpt_pkg::ALIVE_OUT_W) ? CW : nlpt_pkg::ALIVE_OUT_W;

  nlpt_pkg::state_t     state_r, state_nxt;
  nlpt_pkg::item_t      item_r;
  logic [CW-1:0]        loaded_r;
  logic [CW-1:0]        alive_r;
  logic [CW-1:0]        scan_addr_r;
  logic                 out_valid_r;
  nlpt_pkg::res_t       out_r, res_nxt;
  logic [nlpt_pkg::NUT_W-1:0] nut_r [3];

  nlpt_pkg::tbl_ctl_t   tbl_ctl;
  logic [AW-1:0]        wr_addr, rd_addr;
  nlpt_pkg::point_t     wr_point, rd_point, query;
  logic                 rd_live;
  nlpt_pkg::dist_stat_t dist_st;
  logic [AW-1:0]        best_idx;

  logic                 in_accept;
  logic                 out_free;
  logic                 out_load;
  logic                 full;
  logic                 idx_ok;
  logic                 eat_hit;
  logic                 scan_more;
  logic                 scan_done;
  logic                 dist_start;
  logic                 issue;
  logic                 load_do;
  logic                 eat_do;
  logic [SATW-1:0]      alive_wide;
  logic [nlpt_pkg::NUT_W-1:0] eat_nut;

  assign in_accept  = in_ch.valid && in_ch.ready;
  assign out_free   = !out_valid_r || out_ch.ready;
  assign full       = (loaded_r == CW'(TABLE_DEPTH));
  assign idx_ok     = (CMPW'(item_r.index) < CMPW'(loaded_r));
  assign eat_hit    = idx_ok && rd_live;
  assign scan_more  = (scan_addr_r < loaded_r);
  assign scan_done  = !scan_more && !dist_st.busy;
  assign alive_wide = SATW'(alive_r);
  assign dist_start = in_accept && (in_ch.opcode == nlpt_pkg::OP_SEARCH);

  assign query.x    = item_r.pos_x;
  assign query.y    = item_r.pos_y;
  assign query.z    = item_r.pos_z;
  assign query.kind = item_r.kind;

  always_comb begin
    case (rd_point.kind)
      nlpt_pkg::KIND_0: eat_nut = nut_r[0];
      nlpt_pkg::KIND_1: eat_nut = nut_r[1];
      default:          eat_nut = nut_r[2];
    endcase
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      nlpt_pkg::ST_IDLE: begin
        if (in_accept) begin
          unique case (nlpt_pkg::op_t'(in_ch.opcode))
            nlpt_pkg::OP_LOAD:   state_nxt = nlpt_pkg::ST_LOAD;
            nlpt_pkg::OP_SEARCH: state_nxt = nlpt_pkg::ST_SCAN;
            nlpt_pkg::OP_EAT:    state_nxt = nlpt_pkg::ST_EAT_RD;
            default:             state_nxt = nlpt_pkg::ST_COUNT;
          endcase
        end
      end
      nlpt_pkg::ST_LOAD: begin
        if (out_free) state_nxt = nlpt_pkg::ST_IDLE;
      end
      nlpt_pkg::ST_SCAN: begin
        if (scan_done && out_free) state_nxt = nlpt_pkg::ST_IDLE;
      end
      nlpt_pkg::ST_EAT_RD: begin
        state_nxt = nlpt_pkg::ST_EAT_WR;
      end
      nlpt_pkg::ST_EAT_WR: begin
        if (out_free) state_nxt = nlpt_pkg::ST_IDLE;
      end
      nlpt_pkg::ST_COUNT: begin
        if (out_free) state_nxt = nlpt_pkg::ST_IDLE;
      end
      default: state_nxt = nlpt_pkg::ST_IDLE;
    endcase
  end

  // Outputs of the sequencer.
  always_comb begin
    in_ch.ready    = 1'b0;
    tbl_ctl        = '0;
    wr_addr        = loaded_r[AW-1:0];
    rd_addr        = scan_addr_r[AW-1:0];
    wr_point.x     = item_r.pos_x;
    wr_point.y     = item_r.pos_y;
    wr_point.z     = item_r.pos_z;
    wr_point.kind  = (item_r.kind > nlpt_pkg::KIND_W'(nlpt_pkg::KIND_2))
                   ? nlpt_pkg::KIND_W'(nlpt_pkg::KIND_2) : item_r.kind;
    issue          = 1'b0;
    out_load       = 1'b0;
    load_do        = 1'b0;
    eat_do         = 1'b0;
    res_nxt        = '0;
    unique case (state_r)
      nlpt_pkg::ST_IDLE: begin
        in_ch.ready = 1'b1;
      end
      nlpt_pkg::ST_LOAD: begin
        out_load        = out_free;
        load_do         = out_free && !full;
        tbl_ctl.pt_we   = load_do;
        tbl_ctl.live_we = load_do;
        tbl_ctl.live_wd = 1'b1;
        res_nxt.status  = full;
      end
      nlpt_pkg::ST_SCAN: begin
        issue         = scan_more;
        tbl_ctl.rd_en = scan_more;
        out_load      = scan_done && out_free;
        if (dist_st.hit) begin
          res_nxt.found       = 1'b1;
          res_nxt.found_index = nlpt_pkg::IDX_W'(best_idx);
          res_nxt.found_x     = dist_st.best.x;
          res_nxt.found_y     = dist_st.best.y;
          res_nxt.found_z     = dist_st.best.z;
          res_nxt.found_kind  = dist_st.best.kind;
        end
      end
      nlpt_pkg::ST_EAT_RD: begin
        tbl_ctl.rd_en = 1'b1;
        rd_addr       = AW'(item_r.index);
      end
      nlpt_pkg::ST_EAT_WR: begin
        wr_addr           = AW'(item_r.index);
        out_load          = out_free;
        eat_do            = out_free && eat_hit;
        tbl_ctl.live_we   = eat_do;
        tbl_ctl.live_wd   = 1'b0;
        res_nxt.nutrition = eat_hit ? eat_nut : '0;
      end
      nlpt_pkg::ST_COUNT: begin
        out_load = out_free;
        res_nxt.alive_count = (alive_wide > SATW'(nlpt_pkg::ALIVE_SAT))
                            ? nlpt_pkg::ALIVE_OUT_W'(nlpt_pkg::ALIVE_SAT)
                            : nlpt_pkg::ALIVE_OUT_W'(alive_wide);
      end
      default: begin
        in_ch.ready = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= nlpt_pkg::ST_IDLE;
      loaded_r    <= '0;
      alive_r     <= '0;
      scan_addr_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (load_do) begin
        loaded_r <= loaded_r + CW'(1);
        alive_r  <= alive_r + CW'(1);
      end else if (eat_do) begin
        alive_r <= alive_r - CW'(1);
      end
      if (in_accept) begin
        scan_addr_r <= '0;
      end else if (issue) begin
        scan_addr_r <= scan_addr_r + CW'(1);
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      item_r.opcode <= nlpt_pkg::op_t'(in_ch.opcode);
      item_r.pos_x  <= in_ch.pos_x;
      item_r.pos_y  <= in_ch.pos_y;
      item_r.pos_z  <= in_ch.pos_z;
      item_r.kind   <= in_ch.kind;
      item_r.radius <= in_ch.radius;
      item_r.index  <= in_ch.index;
    end
    if (out_load) begin
      out_r <= res_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      nut_r[0] <= nlpt_pkg::NUT_W'(nlpt_pkg::NUT_RESET);
      nut_r[1] <= nlpt_pkg::NUT_W'(nlpt_pkg::NUT_RESET);
      nut_r[2] <= nlpt_pkg::NUT_W'(nlpt_pkg::NUT_RESET);
    end else if (cfg_we) begin
      case (cfg_index)
        nlpt_pkg::REG_NUT_KIND0: nut_r[0] <= cfg_data;
        nlpt_pkg::REG_NUT_KIND1: nut_r[1] <= cfg_data;
        nlpt_pkg::REG_NUT_KIND2: nut_r[2] <= cfg_data;
        default: ;
      endcase
    end
  end

  nlpt_table #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) u_table (
    .clk      (clk),
    .ctl      (tbl_ctl),
    .wr_addr  (wr_addr),
    .rd_addr  (rd_addr),
    .wr_point (wr_point),
    .rd_point (rd_point),
    .rd_live  (rd_live)
  );

  nlpt_dist #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) u_dist (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (dist_start),
    .radius     (in_ch.radius),
    .query      (query),
    .issue      (issue),
    .issue_addr (scan_addr_r[AW-1:0]),
    .rd_point   (rd_point),
    .rd_live    (rd_live),
    .stat       (dist_st),
    .best_idx   (best_idx)
  );

  assign out_ch.valid       = out_valid_r;
  assign out_ch.found       = out_r.found;
  assign out_ch.found_index = out_r.found_index;
  assign out_ch.found_x     = out_r.found_x;
  assign out_ch.found_y     = out_r.found_y;
  assign out_ch.found_z     = out_r.found_z;
  assign out_ch.found_kind  = out_r.found_kind;
  assign out_ch.nutrition   = out_r.nutrition;
  assign out_ch.alive_count = out_r.alive_count;
  assign out_ch.status      = out_r.status;

`ifndef SYNTH
  a_loaded_bound: assert property (@(posedge clk) disable iff (!rst_n)
    loaded_r <= CW'(TABLE_DEPTH))
    else $error("Load count exceeds the table depth.");

  a_alive_bound: assert property (@(posedge clk) disable iff (!rst_n)
    alive_r <= loaded_r)
    else $error("Live count exceeds the load count.");

  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept |=> state_r != nlpt_pkg::ST_IDLE)
    else $error("An accepted transaction did not start an operation.");

  a_scan_drained: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == nlpt_pkg::ST_SCAN && state_nxt == nlpt_pkg::ST_IDLE) |-> !dist_st.busy)
    else $error("Search finished while the distance pipeline held entries.");
`endif

endmodule

`default_nettype wire
